FILE: rtl/core/cnfchk_pkg.sv
package cnfchk_pkg;

    localparam int VAR_INDEX_BITS = 20;
    localparam int COUNT_BITS     = 32;

    localparam int LIT_W        = 21;
    localparam int OUT_CNT_W    = 32;
    localparam int IN_TDATA_W   = ((LIT_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 + 2 * OUT_CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int VAL_W        = 2;

    localparam logic [VAL_W-1:0] VAL_UNSET = 2'd0;
    localparam logic [VAL_W-1:0] VAL_TRUE  = 2'd1;
    localparam logic [VAL_W-1:0] VAL_FALSE = 2'd2;

    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    typedef struct packed {
        logic             op;
        logic             neg;
        logic             zero;
        logic             in_store;
        logic [VAR_INDEX_BITS-1:0] addr;
    } t_lit_info;

endpackage

FILE: rtl/core/cnfchk_ram.sv
module cnfchk_ram #(
    parameter int WIDTH  = 2,
    parameter int ADDR_W = 20
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/cnf_clause_assignment_checker.sv
// an accepted literal is registered in the r_s1 stage, then its result in the output register
// throughput: one literal per cycle unless stalled; one store read and write per cycle
// the variable store is a single-port-write, single-port-read ram with a registered read
// reset: synchronous, active low; counters and clause state clear at once
// after reset a clearing pass writes each of the 2^20 store entries unset,
// during which no input transaction is taken
module cnf_clause_assignment_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // literal[20:0], zero pad
    input  logic [cnfchk_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // clause_closed, clause_satisfied, clause_count[31:0], failed_count[31:0], zero pad
    output logic [cnfchk_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import cnfchk_pkg::*;

    localparam int AW = VAR_INDEX_BITS;

    logic [LIT_W-1:0]      in_lit;
    logic [LIT_W-1:0]      in_mag;
    logic [AW+LIT_W-1:0]   in_mag_ext;
    t_lit_info             in_info;
    logic                  in_accept;

    logic                  r_clr_busy;
    logic [AW-1:0]         r_clr_addr;

    logic                  r_s1_valid;
    t_lit_info             r_s1;
    logic                  s1_move;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VAL_W-1:0]      ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [VAL_W-1:0]      ram_rdata;

    logic                  r_open_sat;
    logic                  r_open_nonempty;
    logic [COUNT_BITS-1:0] r_clause_cnt;
    logic [COUNT_BITS-1:0] r_fail_cnt;
    logic                  n_open_sat;
    logic                  n_open_nonempty;
    logic [COUNT_BITS-1:0] n_clause_cnt;
    logic [COUNT_BITS-1:0] n_fail_cnt;
    logic                  hit;
    logic                  closed;
    logic                  sat;

    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [COUNT_BITS+OUT_CNT_W-1:0] clause_ext;
    logic [COUNT_BITS+OUT_CNT_W-1:0] fail_ext;

    assign in_lit     = s_axis_tdata[LIT_W-1:0];
    assign in_mag     = in_lit[LIT_W-1] ? (~in_lit + LIT_W'(1)) : in_lit;
    assign in_mag_ext = {{AW{1'b0}}, in_mag};

    always_comb begin
        in_info.op       = s_axis_tuser;
        in_info.neg      = in_lit[LIT_W-1];
        in_info.zero     = (in_mag == '0);
        in_info.in_store = ((in_mag_ext >> AW) == '0);
        in_info.addr     = in_mag_ext[AW-1:0];
    end

    assign s1_move       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || s1_move);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // assignments write at accept; a later literal reads on a later edge
    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = VAL_UNSET;
        end else begin
            ram_we    = in_accept && (in_info.op == OP_ASSIGN) && !in_info.zero
                        && in_info.in_store;
            ram_waddr = in_info.addr;
            ram_wdata = in_info.neg ? VAL_FALSE : VAL_TRUE;
        end
        // a stalled item rereads its own entry so the data stays current
        ram_raddr = in_accept ? in_info.addr : r_s1.addr;
    end

    cnfchk_ram #(
        .WIDTH  (VAL_W),
        .ADDR_W (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        hit = r_s1.in_store && !r_s1.zero
              && ((r_s1.neg && ram_rdata == VAL_FALSE) || (!r_s1.neg && ram_rdata == VAL_TRUE));
        closed          = 1'b0;
        sat             = 1'b0;
        n_open_sat      = r_open_sat;
        n_open_nonempty = r_open_nonempty;
        n_clause_cnt    = r_clause_cnt;
        n_fail_cnt      = r_fail_cnt;
        if (r_s1.op == OP_CHECK) begin
            if (r_s1.zero) begin
                closed          = r_open_nonempty;
                sat             = r_open_nonempty && r_open_sat;
                n_open_sat      = 1'b0;
                n_open_nonempty = 1'b0;
                if (r_open_nonempty) begin
                    if (r_clause_cnt != '1) begin
                        n_clause_cnt = r_clause_cnt + COUNT_BITS'(1);
                    end
                    if (!r_open_sat && r_fail_cnt != '1) begin
                        n_fail_cnt = r_fail_cnt + COUNT_BITS'(1);
                    end
                end
            end else begin
                n_open_nonempty = 1'b1;
                n_open_sat      = r_open_sat || hit;
            end
        end
    end

    assign clause_ext = {{OUT_CNT_W{1'b0}}, n_clause_cnt};
    assign fail_ext   = {{OUT_CNT_W{1'b0}}, n_fail_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_open_sat      <= 1'b0;
            r_open_nonempty <= 1'b0;
            r_clause_cnt    <= '0;
            r_fail_cnt      <= '0;
        end else begin
            if (!r_s1_valid || s1_move) begin
                r_s1_valid <= in_accept;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_open_sat      <= n_open_sat;
                    r_open_nonempty <= n_open_nonempty;
                    r_clause_cnt    <= n_clause_cnt;
                    r_fail_cnt      <= n_fail_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= in_info;
        end
        if (s1_move && r_s1_valid) begin
            r_out_data <= OUT_TDATA_W'({fail_ext[OUT_CNT_W-1:0], clause_ext[OUT_CNT_W-1:0],
                                        sat, closed});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready)
        else $error("input taken during store clearing pass");

    a_fail_le_clause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fail_cnt <= r_clause_cnt)
        else $error("failed count exceeds clause count");

    a_sat_needs_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
        else $error("satisfied flag without closed clause");

    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> r_s1_valid)
        else $error("stalled literal lost");

endmodule

FILE: sim/cnf_clause_assignment_checker_tb.sv
`timescale 1ns / 100ps

module cnf_clause_assignment_checker_tb;
    import cnfchk_pkg::*;

    localparam int LIMIT_CYCLES = 6_000_000;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_TAIL    = 80;
    localparam int STORE_DEPTH  = 1 << VAR_INDEX_BITS;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

    typedef struct packed {
        logic                 closed;
        logic                 sat;
        logic [OUT_CNT_W-1:0] clauses;
        logic [OUT_CNT_W-1:0] failures;
    } t_clause_result;

    typedef struct packed {
        logic           op;
        int             lit;
        logic           typed;
        t_clause_result res;
    } t_directed_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // literal[20:0], zero pad
    logic                   s_axis_tuser;   // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // clause_closed, clause_satisfied, clause_count[31:0], failed_count[31:0], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [VAL_W-1:0] var_value [STORE_DEPTH];
    logic             open_sat;
    logic             open_nonempty;
    longint unsigned  clause_total;
    longint unsigned  fail_total;

    t_clause_result   pending_results [$];
    t_directed_row    directed_rows [$];
    logic             drive_typed;
    t_clause_result   drive_expect;
    int               errors;
    int               cycle_count;
    int               src_idle_pct;
    int               snk_idle_pct;
    int               sink_hold;

    cnf_clause_assignment_checker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_clause_result evaluate_literal(logic op, logic [LIT_W-1:0] lit);
        t_clause_result r;
        logic           neg;
        int             mag;
        neg = lit[LIT_W-1];
        mag = neg ? -int'($signed(lit)) : int'(lit);
        r = '0;
        if (op == OP_ASSIGN) begin
            if (mag != 0 && mag < STORE_DEPTH) begin
                var_value[mag] = neg ? VAL_FALSE : VAL_TRUE;
            end
        end else if (mag == 0) begin
            if (open_nonempty) begin
                r.closed = 1'b1;
                r.sat    = open_sat;
                if (clause_total < COUNT_MAX) begin
                    clause_total++;
                end
                if (!open_sat && fail_total < COUNT_MAX) begin
                    fail_total++;
                end
            end
            open_sat      = 1'b0;
            open_nonempty = 1'b0;
        end else begin
            open_nonempty = 1'b1;
            if (mag < STORE_DEPTH && var_value[mag] == (neg ? VAL_FALSE : VAL_TRUE)) begin
                open_sat = 1'b1;
            end
        end
        r.clauses  = OUT_CNT_W'(clause_total);
        r.failures = OUT_CNT_W'(fail_total);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [OUT_CNT_W-1:0] want,
                               input logic [OUT_CNT_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // prediction at input acceptance, comparison at output acceptance
    always @(posedge i_clk) begin : scoreboard
        t_clause_result predicted;
        t_clause_result seen;
        t_clause_result want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predicted = evaluate_literal(s_axis_tuser, s_axis_tdata[LIT_W-1:0]);
            pending_results.push_back(drive_typed ? drive_expect : predicted);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.closed   = m_axis_tdata[0];
            seen.sat      = m_axis_tdata[1];
            seen.clauses  = m_axis_tdata[2 +: OUT_CNT_W];
            seen.failures = m_axis_tdata[2 + OUT_CNT_W +: OUT_CNT_W];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none got %h",
                         $time, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("clause_closed", OUT_CNT_W'(want.closed), OUT_CNT_W'(seen.closed));
                check_field("clause_satisfied", OUT_CNT_W'(want.sat), OUT_CNT_W'(seen.sat));
                check_field("clause_count", want.clauses, seen.clauses);
                check_field("failed_count", want.failures, seen.failures);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("cnf_clause_assignment_checker regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < snk_idle_pct) begin
            sink_hold = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // entered and left at a falling edge
    task automatic send_lit(input logic op, input int lit, input logic typed,
                            input t_clause_result expect_res);
        logic [LIT_W-1:0] lit_bits;
        lit_bits = LIT_W'(lit);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_TDATA_W - LIT_W){1'b0}}, lit_bits};
        drive_typed   = typed;
        drive_expect  = expect_res;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic op, input int lit, input logic typed, input logic closed,
                           input logic sat, input int clauses, input int failures);
        t_directed_row row;
        row.op           = op;
        row.lit          = lit;
        row.typed        = typed;
        row.res.closed   = closed;
        row.res.sat      = sat;
        row.res.clauses  = OUT_CNT_W'(clauses);
        row.res.failures = OUT_CNT_W'(failures);
        directed_rows.push_back(row);
    endtask

    function automatic int pick_lit();
        int sel;
        int mag;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            mag = $urandom_range(1, 24);
        end else if (sel < 85) begin
            mag = $urandom_range(STORE_DEPTH - 16, STORE_DEPTH - 1);
        end else if (sel < 95) begin
            mag = $urandom_range(1, STORE_DEPTH - 1);
        end else begin
            return -STORE_DEPTH;
        end
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic int idle_level();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    initial begin : stimulus
        int sent;
        int kind;
        int n;
        logic pressure_done;
        foreach (var_value[i]) begin
            var_value[i] = VAL_UNSET;
        end
        open_sat      = 1'b0;
        open_nonempty = 1'b0;
        clause_total  = 0;
        fail_total    = 0;
        errors        = 0;
        cycle_count   = 0;
        sink_hold     = 0;
        src_idle_pct  = 20;
        snk_idle_pct  = 20;
        drive_typed   = 1'b0;
        drive_expect  = '0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = OP_ASSIGN;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(OP_CHECK,        0, 1, 0, 0, 0, 0);  // empty clause after reset
        add_row(OP_ASSIGN,       0, 1, 0, 0, 0, 0);
        add_row(OP_ASSIGN,       1, 1, 0, 0, 0, 0);
        add_row(OP_ASSIGN,      -2, 1, 0, 0, 0, 0);
        add_row(OP_ASSIGN, 1048575, 1, 0, 0, 0, 0);
        add_row(OP_ASSIGN,-1048576, 1, 0, 0, 0, 0);  // outside the store
        add_row(OP_ASSIGN,-1048575, 1, 0, 0, 0, 0);  // reassignment
        add_row(OP_CHECK,        1, 1, 0, 0, 0, 0);
        add_row(OP_CHECK,        0, 1, 1, 1, 1, 0);
        add_row(OP_CHECK,       -1, 1, 0, 0, 1, 0);
        add_row(OP_CHECK,        0, 1, 1, 0, 2, 1);
        add_row(OP_CHECK,        3, 0, 0, 0, 0, 0);  // unset variable
        add_row(OP_CHECK,        0, 1, 1, 0, 3, 2);
        add_row(OP_CHECK, -1048576, 1, 0, 0, 3, 2);
        add_row(OP_CHECK,        0, 1, 1, 0, 4, 3);
        add_row(OP_CHECK, -1048575, 1, 0, 0, 4, 3);
        add_row(OP_CHECK,        0, 1, 1, 1, 5, 3);
        add_row(OP_CHECK,  1048575, 0, 0, 0, 0, 0);
        add_row(OP_CHECK,       -2, 0, 0, 0, 0, 0);
        add_row(OP_CHECK,        0, 1, 1, 1, 6, 3);
        add_row(OP_ASSIGN,       2, 0, 0, 0, 0, 0);
        add_row(OP_CHECK,       -2, 0, 0, 0, 0, 0);
        add_row(OP_CHECK,        0, 1, 1, 0, 7, 4);
        add_row(OP_CHECK,        0, 1, 0, 0, 7, 4);
        foreach (directed_rows[i]) begin
            send_lit(directed_rows[i].op, directed_rows[i].lit, directed_rows[i].typed,
                     directed_rows[i].res);
        end

        sent = 0;
        pressure_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if ($urandom_range(0, 7) == 0) begin
                src_idle_pct = idle_level();
                snk_idle_pct = idle_level();
            end
            if (!pressure_done && sent >= RANDOM_ITEMS / 2) begin
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
                pressure_done = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                n = $urandom_range(1, 8);
                repeat (n) send_lit(OP_ASSIGN, pick_lit(), 1'b0, '0);
                send_lit(OP_ASSIGN, 0, 1'b0, '0);
                sent += n + 1;
            end else if (kind < 85) begin
                n = $urandom_range(1, 5);
                repeat (n) send_lit(OP_CHECK, pick_lit(), 1'b0, '0);
                send_lit(OP_CHECK, 0, 1'b0, '0);
                sent += n + 1;
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    send_lit(logic'($urandom_range(0, 1)),
                             ($urandom_range(0, 3) == 0) ? 0 : int'($urandom), 1'b0, '0);
                end
                sent += n;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("cnf_clause_assignment_checker regression: pass");
        end else begin
            $display("cnf_clause_assignment_checker regression: fail");
        end
        $finish;
    end

endmodule
